@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared assertion forms, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("assertion failed");

// The expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error("forbidden condition seen");

`endif

@@ rtl/core/msic_pkg.sv @@
// ----------------------------------------------------------------------------
// msic_pkg
// Types and constants shared by the merge sort and inversion count unit.
// ----------------------------------------------------------------------------
package msic_pkg;

   localparam int DATA_W  = 32;
   localparam int COUNT_W = 11;

   typedef logic signed [DATA_W-1:0] data_type;
   typedef logic [COUNT_W-1:0]       count_type;

   // Status from the merge engine to the top level.
   typedef struct packed {
      logic done;
      logic src_sel;
   } sort_status_type;

endpackage

@@ rtl/core/msic_ram.sv @@
// ----------------------------------------------------------------------------
// msic_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module msic_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

@@ rtl/core/msic_merge_engine.sv @@
// ----------------------------------------------------------------------------
// msic_merge_engine
// Bottom-up merge sequencer. Each pass reads runs from the source RAM, merges
// them into the other RAM and counts inversions; the RAMs swap every pass.
// ----------------------------------------------------------------------------
module msic_merge_engine #(
   parameter int MAX_ELEMENTS = 64,
   localparam int AW = $clog2(MAX_ELEMENTS),
   localparam int CW = $clog2(MAX_ELEMENTS + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CW-1:0]            count,
   input  msic_pkg::data_type       rdata,
   output logic [AW-1:0]            raddr,
   output logic                     we,
   output logic [AW-1:0]            waddr,
   output msic_pkg::data_type       wdata,
   output msic_pkg::count_type      inv_total,
   output msic_pkg::sort_status_type status
);

   import msic_pkg::*;

   localparam int PW = CW + 1;

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_FETCH_L  = 3'd1;
   localparam logic [2:0] ST_FETCH_R  = 3'd2;
   localparam logic [2:0] ST_HEAD_R   = 3'd3;
   localparam logic [2:0] ST_MERGE    = 3'd4;
   localparam logic [2:0] ST_REFILL_L = 3'd5;
   localparam logic [2:0] ST_REFILL_R = 3'd6;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] n_ff, n_in;
   logic [PW-1:0] width_ff, width_in;
   logic [PW-1:0] lo_ff, lo_in;
   logic [PW-1:0] i_ff, i_in;
   logic [PW-1:0] mid_ff, mid_in;
   logic [PW-1:0] j_ff, j_in;
   logic [PW-1:0] hi_ff, hi_in;
   logic [PW-1:0] k_ff, k_in;
   data_type      head_l_ff, head_l_in;
   data_type      head_r_ff, head_r_in;
   logic          src_sel_ff, src_sel_in;
   count_type     inv_ff, inv_in;
   logic          done_ff, done_in;

   logic [PW-1:0] seg_n, seg_lo, seg_w, seg_mid, seg_hi;
   logic [PW-1:0] next_lo, next_w, lo_plus_w, lo_plus_2w;
   logic          take_right;

   assign next_lo = lo_ff + (width_ff << 1);
   assign next_w  = width_ff << 1;

   // Bounds of the next pair of runs, clipped to the element count.
   always_comb begin
      seg_n = (state_ff == ST_IDLE) ? {1'b0, count} : {1'b0, n_ff};
      if (state_ff == ST_IDLE) begin
         seg_lo = '0;
         seg_w  = PW'(1);
      end else if (next_lo < seg_n) begin
         seg_lo = next_lo;
         seg_w  = width_ff;
      end else begin
         seg_lo = '0;
         seg_w  = next_w;
      end
      lo_plus_w  = seg_lo + seg_w;
      lo_plus_2w = seg_lo + (seg_w << 1);
      seg_mid    = (lo_plus_w < seg_n) ? lo_plus_w : seg_n;
      seg_hi     = (lo_plus_2w < seg_n) ? lo_plus_2w : seg_n;
   end

   // Ties take the left element, so equal pairs never count.
   assign take_right = (j_ff < hi_ff) && ((i_ff >= mid_ff) || (head_l_ff > head_r_ff));

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      width_in   = width_ff;
      lo_in      = lo_ff;
      i_in       = i_ff;
      mid_in     = mid_ff;
      j_in       = j_ff;
      hi_in      = hi_ff;
      k_in       = k_ff;
      head_l_in  = head_l_ff;
      head_r_in  = head_r_ff;
      src_sel_in = src_sel_ff;
      inv_in     = inv_ff;
      done_in    = 1'b0;
      we         = 1'b0;
      waddr      = k_ff[AW-1:0];
      wdata      = take_right ? head_r_ff : head_l_ff;
      raddr      = i_ff[AW-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in       = count;
               inv_in     = '0;
               src_sel_in = 1'b0;
               if (count > CW'(1)) begin
                  lo_in    = seg_lo;
                  width_in = seg_w;
                  i_in     = seg_lo;
                  mid_in   = seg_mid;
                  j_in     = seg_mid;
                  hi_in    = seg_hi;
                  k_in     = seg_lo;
                  state_in = ST_FETCH_L;
               end else begin
                  done_in = 1'b1;
               end
            end
         end
         ST_FETCH_L: begin
            raddr    = i_ff[AW-1:0];
            state_in = ST_FETCH_R;
         end
         ST_FETCH_R: begin
            raddr     = j_ff[AW-1:0];
            head_l_in = rdata;
            state_in  = ST_HEAD_R;
         end
         ST_HEAD_R: begin
            head_r_in = rdata;
            state_in  = ST_MERGE;
         end
         ST_MERGE: begin
            we   = 1'b1;
            k_in = k_ff + PW'(1);
            if (take_right) begin
               j_in     = j_ff + PW'(1);
               raddr    = j_in[AW-1:0];
               inv_in   = inv_ff + count_type'(mid_ff - i_ff);
               state_in = ST_REFILL_R;
            end else begin
               i_in     = i_ff + PW'(1);
               raddr    = i_in[AW-1:0];
               state_in = ST_REFILL_L;
            end
            if (k_ff + PW'(1) == hi_ff) begin
               // The pair of runs is finished: move on or end the pass.
               if (next_lo >= {1'b0, n_ff}) begin
                  src_sel_in = ~src_sel_ff;
               end
               if ((next_lo < {1'b0, n_ff}) || (next_w < {1'b0, n_ff})) begin
                  lo_in    = seg_lo;
                  width_in = seg_w;
                  i_in     = seg_lo;
                  mid_in   = seg_mid;
                  j_in     = seg_mid;
                  hi_in    = seg_hi;
                  k_in     = seg_lo;
                  state_in = ST_FETCH_L;
               end else begin
                  done_in  = 1'b1;
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REFILL_L: begin
            head_l_in = rdata;
            state_in  = ST_MERGE;
         end
         ST_REFILL_R: begin
            head_r_in = rdata;
            state_in  = ST_MERGE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         src_sel_ff <= 1'b0;
         inv_ff     <= '0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         src_sel_ff <= src_sel_in;
         inv_ff     <= inv_in;
         done_ff    <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      width_ff  <= width_in;
      lo_ff     <= lo_in;
      i_ff      <= i_in;
      mid_ff    <= mid_in;
      j_ff      <= j_in;
      hi_ff     <= hi_in;
      k_ff      <= k_in;
      head_l_ff <= head_l_in;
      head_r_ff <= head_r_in;
   end

   assign inv_total      = inv_ff;
   assign status.done    = done_ff;
   assign status.src_sel = src_sel_ff;

endmodule

@@ rtl/core/merge_sort_inversion_count_unit.sv @@
// Loading accepts one transfer per cycle, and input is stalled while a set is
// sorted or streamed out; the item marked last starts the sort. Sorting n
// elements takes ceil(log2(n)) merge passes, each paced by the single read
// port of the source RAM. Each result is read, loaded into the output
// register and then held until it is taken, before the next one is read.
// Synchronous reset clears the control state only.
// ----------------------------------------------------------------------------
// merge_sort_inversion_count_unit
// Collects a set of signed values, merge-sorts it in two ping-pong RAMs while
// counting inversions, then streams the sorted values with the count.
// ----------------------------------------------------------------------------
module merge_sort_inversion_count_unit #(
   parameter int MAX_ELEMENTS = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  msic_pkg::data_type   req_value_in,
   input  logic                 req_last_in,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output msic_pkg::data_type   rsp_sorted_value,
   output msic_pkg::count_type  rsp_inversion_count,
   output logic                 rsp_last_out
);

   import msic_pkg::*;

   localparam int AW = $clog2(MAX_ELEMENTS);
   localparam int CW = $clog2(MAX_ELEMENTS + 1);

   localparam logic [2:0] T_LOAD     = 3'd0;
   localparam logic [2:0] T_SORT     = 3'd1;
   localparam logic [2:0] T_OUT_RD   = 3'd2;
   localparam logic [2:0] T_OUT_LD   = 3'd3;
   localparam logic [2:0] T_OUT_WAIT = 3'd4;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [AW-1:0] out_idx_ff, out_idx_in;
   logic          rsp_valid_ff, rsp_valid_in;
   data_type      rsp_value_ff, rsp_value_in;
   count_type     rsp_count_ff, rsp_count_in;
   logic          rsp_last_out_ff, rsp_last_out_in;

   logic          req_take, has_room, load_we, sort_start;
   logic [CW-1:0] fill_next;

   logic            eng_we;
   logic [AW-1:0]   eng_waddr, eng_raddr;
   data_type        eng_wdata;
   count_type       eng_inv;
   sort_status_type eng_status;

   logic            ram_a_we, ram_b_we;
   logic [AW-1:0]   ram_a_waddr, ram_raddr;
   data_type        ram_a_wdata, rd_a, rd_b, rd_src;

   assign req_stall = (state_ff != T_LOAD);
   assign req_take  = req_valid && !req_stall;
   assign has_room  = fill_ff < CW'(MAX_ELEMENTS);
   assign load_we   = req_take && has_room;
   assign fill_next = load_we ? fill_ff + CW'(1) : fill_ff;
   assign sort_start = req_take && req_last_in;

   // Loads go to RAM A; during a pass the engine writes whichever RAM is not
   // the source of that pass.
   assign ram_a_we    = load_we || (eng_we && eng_status.src_sel);
   assign ram_b_we    = eng_we && !eng_status.src_sel;
   assign ram_a_waddr = (state_ff == T_LOAD) ? fill_ff[AW-1:0] : eng_waddr;
   assign ram_a_wdata = (state_ff == T_LOAD) ? req_value_in : eng_wdata;
   assign ram_raddr   = (state_ff == T_SORT) ? eng_raddr : out_idx_ff;
   assign rd_src      = eng_status.src_sel ? rd_b : rd_a;

   msic_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram_a (
      .clock (clock),
      .we    (ram_a_we),
      .waddr (ram_a_waddr),
      .wdata (ram_a_wdata),
      .raddr (ram_raddr),
      .rdata (rd_a)
   );

   msic_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_ELEMENTS)
   ) u_ram_b (
      .clock (clock),
      .we    (ram_b_we),
      .waddr (eng_waddr),
      .wdata (eng_wdata),
      .raddr (ram_raddr),
      .rdata (rd_b)
   );

   msic_merge_engine #(
      .MAX_ELEMENTS (MAX_ELEMENTS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .start     (sort_start),
      .count     (fill_next),
      .rdata     (rd_src),
      .raddr     (eng_raddr),
      .we        (eng_we),
      .waddr     (eng_waddr),
      .wdata     (eng_wdata),
      .inv_total (eng_inv),
      .status    (eng_status)
   );

   always_comb begin
      state_in        = state_ff;
      fill_in         = fill_ff;
      out_idx_in      = out_idx_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_value_in    = rsp_value_ff;
      rsp_count_in    = rsp_count_ff;
      rsp_last_out_in = rsp_last_out_ff;

      unique case (state_ff)
         T_LOAD: begin
            fill_in = fill_next;
            if (sort_start) begin
               out_idx_in = '0;
               state_in   = T_SORT;
            end
         end
         T_SORT: begin
            if (eng_status.done) begin
               state_in = T_OUT_RD;
            end
         end
         T_OUT_RD: begin
            state_in = T_OUT_LD;
         end
         T_OUT_LD: begin
            rsp_value_in    = rd_src;
            rsp_count_in    = eng_inv;
            rsp_last_out_in = (CW'(out_idx_ff) + CW'(1) == fill_ff);
            rsp_valid_in    = 1'b1;
            state_in        = T_OUT_WAIT;
         end
         T_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               if (rsp_last_out_ff) begin
                  fill_in  = '0;
                  state_in = T_LOAD;
               end else begin
                  out_idx_in = out_idx_ff + AW'(1);
                  state_in   = T_OUT_RD;
               end
            end
         end
         default: begin
            state_in = T_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= T_LOAD;
         fill_ff      <= '0;
         out_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         out_idx_ff   <= out_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff    <= rsp_value_in;
      rsp_count_ff    <= rsp_count_in;
      rsp_last_out_ff <= rsp_last_out_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_sorted_value    = rsp_value_ff;
   assign rsp_inversion_count = rsp_count_ff;
   assign rsp_last_out        = rsp_last_out_ff;

endmodule

@@ rtl/core/msic_checker.sv @@
// ----------------------------------------------------------------------------
// msic_checker
// Port-level assertions for the merge sort and inversion count unit.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module msic_checker (
   input logic                clock,
   input logic                reset,
   input logic                req_valid,
   input logic                req_stall,
   input logic                req_last_in,
   input logic                rsp_valid,
   input logic                rsp_stall,
   input msic_pkg::data_type  rsp_sorted_value,
   input msic_pkg::count_type rsp_inversion_count,
   input logic                rsp_last_out
);

   // A stalled result stays offered and unchanged.
   `ASSERT_ALWAYS(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_sorted_value) && $stable(rsp_last_out))

   // No new set is taken while results of the current one are offered.
   `ASSERT_NEVER(a_no_load_during_output, rsp_valid && !req_stall)

   // The transfer that ends a set starts the sort, so input is held off.
   `ASSERT_ALWAYS(a_last_starts_sort, req_valid && !req_stall && req_last_in |=> req_stall)

   // Every result of one set carries the same inversion count.
   `ASSERT_ALWAYS(a_count_steady, rsp_valid && !rsp_stall && !rsp_last_out |=> $stable(rsp_inversion_count))

endmodule

bind merge_sort_inversion_count_unit msic_checker u_checker (.*);

@@ verif/tb_merge_sort_inversion_count_unit.sv @@
// ----------------------------------------------------------------------------
// tb_merge_sort_inversion_count_unit
// Loads sets of signed values into the sort unit and checks every sorted
// value, its inversion count and its last mark against a local predictor,
// under random idling on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_merge_sort_inversion_count_unit;
   import msic_pkg::*;

   localparam int       SET_CAPACITY = 64;
   localparam data_type DATA_MAX     = 32'sh7FFF_FFFF;
   localparam data_type DATA_MIN     = 32'sh8000_0000;
   localparam int       HOLD_AT      = 250;
   localparam int       HOLD_CYCLES  = 1500;
   localparam int       RANDOM_ITEMS = 320;

   typedef struct packed {
      data_type  value;
      logic      last;
      logic      known;
      data_type  known_value;
      count_type known_count;
   } stim_row_type;

   typedef struct packed {
      data_type  value;
      count_type count;
      logic      last;
   } sorted_result_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      req_valid = 1'b0;
   logic      req_stall;
   data_type  req_value_in = '0;
   logic      req_last_in = 1'b0;
   logic      rsp_valid;
   logic      rsp_stall = 1'b0;
   data_type  rsp_sorted_value;
   count_type rsp_inversion_count;
   logic      rsp_last_out;

   data_type          pending_set[$];
   sorted_result_type sorted_expect[$];
   int                items_sent = 0;
   int                mismatches = 0;
   int                send_idle_pct = 12;
   int                recv_idle_pct = 49;
   logic              hold_done = 1'b0;

   // Rows that end a one-element set carry their result typed in.
   stim_row_type stim_rows [18] = '{
      '{32'sd0,   1'b1, 1'b1, 32'sd0,   11'd0},
      '{DATA_MAX, 1'b1, 1'b1, DATA_MAX, 11'd0},
      '{DATA_MIN, 1'b1, 1'b1, DATA_MIN, 11'd0},
      '{DATA_MAX, 1'b0, 1'b0, 32'sd0,   11'd0},
      '{DATA_MIN, 1'b1, 1'b0, 32'sd0,   11'd0},
      '{32'sd5,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd5,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd5,   1'b1, 1'b0, 32'sd0,   11'd0},
      '{32'sd3,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd2,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd1,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd0,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{-32'sd1,  1'b0, 1'b0, 32'sd0,   11'd0},
      '{-32'sd2,  1'b1, 1'b0, 32'sd0,   11'd0},
      '{-32'sd1,  1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd0,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{32'sd1,   1'b0, 1'b0, 32'sd0,   11'd0},
      '{-32'sd1,  1'b1, 1'b0, 32'sd0,   11'd0}
   };

   merge_sort_inversion_count_unit #(
      .MAX_ELEMENTS(SET_CAPACITY)
   ) DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_value_in       (req_value_in),
      .req_last_in        (req_last_in),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_sorted_value   (rsp_sorted_value),
      .rsp_inversion_count(rsp_inversion_count),
      .rsp_last_out       (rsp_last_out)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("mismatch: %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // Stores one accepted value while the set has room; a set end sorts the held
   // values and, when emit is set, queues one result per value, each with the pair count of the whole set.
   function automatic void load_value(input data_type value, input logic last,
                                      input logic emit);
      data_type  ordered[$];
      data_type  moving;
      int        pairs;
      int        j;
      count_type total;
      pairs = 0;
      if (pending_set.size() < SET_CAPACITY)
         pending_set.push_back(value);
      if (!last)
         return;
      for (int a = 0; a < pending_set.size(); a++) begin
         for (int b = a + 1; b < pending_set.size(); b++) begin
            if (pending_set[a] > pending_set[b])
               pairs++;
         end
      end
      ordered = pending_set;
      for (int a = 1; a < ordered.size(); a++) begin
         moving = ordered[a];
         j = a - 1;
         while (j >= 0 && ordered[j] > moving) begin
            ordered[j + 1] = ordered[j];
            j--;
         end
         ordered[j + 1] = moving;
      end
      total = count_type'(pairs);
      if (emit) begin
         foreach (ordered[k])
            sorted_expect.push_back('{ordered[k], total, k == ordered.size() - 1});
      end
      pending_set.delete();
   endfunction

   task automatic send_item(input stim_row_type row);
      if (items_sent < 110) begin
         send_idle_pct = 12;
         recv_idle_pct = 49;
      end else if (items_sent < 220) begin
         send_idle_pct = 49;
         recv_idle_pct = 12;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_value_in <= row.value;
      req_last_in  <= row.last;
      do
         @(posedge clock);
      while (req_stall);
      items_sent++;
      load_value(row.value, row.last, !row.known);
      if (row.known)
         sorted_expect.push_back('{row.known_value, row.known_count, 1'b1});
   endtask

   function automatic data_type pick_value();
      int kind;
      kind = $urandom_range(0, 99);
      if (kind < 50)
         return data_type'($urandom);
      if (kind < 80)
         return data_type'($signed($urandom_range(0, 8)) - 4);
      case ($urandom_range(0, 4))
         0: return DATA_MAX;
         1: return DATA_MIN;
         2: return 32'sd0;
         3: return -32'sd1;
         default: return 32'sd1;
      endcase
   endfunction

   task automatic send_set(input int length, input logic descending);
      stim_row_type row;
      for (int k = 0; k < length; k++) begin
         row = '0;
         row.value = descending ? data_type'((length - 1 - k - 32) * 1000003) : pick_value();
         row.last  = (k == length - 1);
         send_item(row);
      end
   endtask

   initial begin
      int choice;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (stim_rows[r])
         send_item(stim_rows[r]);
      // A reversed full set reaches the largest count; an overfull set ends
      // on a value that is dropped.
      send_set(SET_CAPACITY, 1'b1);
      send_set(SET_CAPACITY + 2, 1'b0);
      while (items_sent < RANDOM_ITEMS) begin
         choice = $urandom_range(0, 99);
         if (choice < 80)
            send_set($urandom_range(1, 8), 1'b0);
         else if (choice < 92)
            send_set($urandom_range(9, 20), 1'b0);
         else if (choice < 97)
            send_set(SET_CAPACITY, 1'b0);
         else
            send_set($urandom_range(SET_CAPACITY + 1, SET_CAPACITY + 4), 1'b0);
      end
      req_valid <= 1'b0;
      while (sorted_expect.size() != 0)
         @(posedge clock);
      repeat (30) @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // Output side: random stalls, plus one long hold-off so that the unit
   // backs up and stalls its input.
   initial begin
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            hold_done = 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      sorted_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_expect.size() == 0) begin
            report_mismatch("result with none pending", rsp_sorted_value, 0);
         end else begin
            want = sorted_expect.pop_front();
            if (rsp_sorted_value !== want.value)
               report_mismatch("sorted_value", rsp_sorted_value, want.value);
            if (rsp_inversion_count !== want.count)
               report_mismatch("inversion_count", rsp_inversion_count, want.count);
            if (rsp_last_out !== want.last)
               report_mismatch("last_out", rsp_last_out, want.last);
         end
      end
   end

   initial begin
      #4000000;
      $display("FAIL");
      $finish;
   end

endmodule
